// ===== hw/rtl/ecqs_pkg.sv =====
package ecqs_pkg;

   // Defaults for the top-level parameters
   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int FLOOR_BITS_DEF  = 8;

   // Fixed port widths
   localparam int OP_BITS     = 2;
   localparam int CALL_BITS   = 8;
   localparam int STATUS_BITS = 2;
   localparam int DIST_BITS   = 13;
   localparam int STOP_BITS   = 4;
   localparam int OCC_BITS    = 5;

   localparam logic [DIST_BITS-1:0] DIST_MAX = 13'd8191;
   localparam logic [STOP_BITS-1:0] STOP_MAX = 4'd15;
   localparam logic [OCC_BITS-1:0]  OCC_MAX  = 5'd31;

   typedef enum logic [OP_BITS-1:0] {
      OP_ADD      = 2'd0,
      OP_POP      = 2'd1,
      OP_ESTIMATE = 2'd2,
      OP_REPORT   = 2'd3
   } op_type;

   localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd2;

endpackage

// ===== hw/rtl/elevator_call_queue_scheduler.sv =====
// Pop moves each entry behind the head forward one slot with a read and a write;
// estimate walks the queue entry by entry; add walks to the insert point, then
// shifts the entries behind it back one slot each. Report gives one beat per entry.
// Throughput: one request at a time; req_stall is high whenever the FSM is not idle.
// Reset: synchronous, clears the fill count and control; queue memory is not cleared.
module elevator_call_queue_scheduler #(
   parameter int QUEUE_DEPTH = ecqs_pkg::QUEUE_DEPTH_DEF,
   parameter int FLOOR_BITS  = ecqs_pkg::FLOOR_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [ecqs_pkg::OP_BITS-1:0]       req_operation,
   input  logic [ecqs_pkg::CALL_BITS-1:0]     req_call_floor,
   input  logic                               req_call_up,
   input  logic                               req_call_set,
   input  logic [ecqs_pkg::CALL_BITS-1:0]     req_car_floor,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [ecqs_pkg::STATUS_BITS-1:0]   rsp_status,
   output logic [ecqs_pkg::DIST_BITS-1:0]     rsp_distance,
   output logic [ecqs_pkg::CALL_BITS-1:0]     rsp_entry_floor,
   output logic                               rsp_entry_up,
   output logic [ecqs_pkg::DIST_BITS-1:0]     rsp_floors_before,
   output logic [ecqs_pkg::STOP_BITS-1:0]     rsp_stops_before,
   output logic                               rsp_last,
   output logic [ecqs_pkg::OCC_BITS-1:0]      rsp_occupancy
);
   import ecqs_pkg::*;

   localparam int IDX_W   = $clog2(QUEUE_DEPTH);
   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int ENTRY_W = FLOOR_BITS + 2;
   localparam int ACC_RAW = FLOOR_BITS + CNT_W + 1;
   localparam int ACC_W   = (ACC_RAW > DIST_BITS + 1) ? ACC_RAW : DIST_BITS + 1;
   localparam int EXT_W   = (FLOOR_BITS > CALL_BITS) ? FLOOR_BITS : CALL_BITS;
   localparam int OCC_W   = (CNT_W > OCC_BITS) ? CNT_W : OCC_BITS;
   localparam int STP_W   = (CNT_W > STOP_BITS) ? CNT_W : STOP_BITS;

   typedef enum logic [3:0] {
      S_IDLE, S_LOC_RD, S_LOC_CHK, S_LOC_END, S_SH_RD, S_SH_WR,
      S_POP_RD, S_POP_WR, S_REP_RD, S_REP_OUT, S_DONE
   } state_type;

   function automatic logic [FLOOR_BITS-1:0] gap(input logic [FLOOR_BITS-1:0] a,
                                                 input logic [FLOOR_BITS-1:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   function automatic logic [DIST_BITS-1:0] sat_dist(input logic [ACC_W-1:0] v);
      return (v > ACC_W'(DIST_MAX)) ? DIST_MAX : v[DIST_BITS-1:0];
   endfunction

   // Queue memory: {set, up, floor}
   logic [ENTRY_W-1:0] queue_ff [QUEUE_DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   state_type             state_ff;
   logic [CNT_W-1:0]      fill_ff;
   logic [CNT_W-1:0]      idx_ff;
   logic [CNT_W-1:0]      pos_ff;
   op_type                op_ff;
   logic [FLOOR_BITS-1:0] tgt_ff;
   logic                  up_ff;
   logic                  set_ff;
   logic [FLOOR_BITS-1:0] car_ff;
   logic [FLOOR_BITS-1:0] prev_floor_ff;
   logic                  prev_up_ff;
   logic [ACC_W-1:0]      acc_ff;
   logic [STATUS_BITS-1:0] status_ff;

   logic                   rsp_valid_ff;
   logic [STATUS_BITS-1:0] rsp_status_ff;
   logic [DIST_BITS-1:0]   rsp_distance_ff;
   logic [CALL_BITS-1:0]   rsp_entry_floor_ff;
   logic                   rsp_entry_up_ff;
   logic [DIST_BITS-1:0]   rsp_floors_before_ff;
   logic [STOP_BITS-1:0]   rsp_stops_before_ff;
   logic                   rsp_last_ff;
   logic [OCC_BITS-1:0]    rsp_occupancy_ff;

   // Memory port control
   logic               mem_re;
   logic [IDX_W-1:0]   mem_raddr;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   logic [ENTRY_W-1:0] mem_wdata;

   logic [EXT_W-1:0]      in_call_ext;
   logic [EXT_W-1:0]      in_car_ext;
   logic [FLOOR_BITS-1:0] in_tgt;
   logic [FLOOR_BITS-1:0] in_car;
   logic [FLOOR_BITS-1:0] rd_floor;
   logic                  rd_up;
   logic                  head_hit;
   logic                  mid_hit;
   logic                  out_free;
   logic                  rsp_load;
   logic                  accept;
   logic [ACC_W-1:0]      acc_hop;
   logic [ACC_W-1:0]      acc_to_tgt;
   logic [ACC_W-1:0]      rep_dist;
   logic [EXT_W-1:0]      rd_floor_ext;
   logic [OCC_W-1:0]      fill_ext;
   logic [OCC_BITS-1:0]   occ_sat;
   logic [STP_W-1:0]      idx_ext;
   logic [STOP_BITS-1:0]  stops_sat;
   logic [CNT_W-1:0]      idx_dec;
   logic [CNT_W-1:0]      idx_inc;

   assign in_call_ext = EXT_W'(req_call_floor);
   assign in_car_ext  = EXT_W'(req_car_floor);
   assign in_tgt      = in_call_ext[FLOOR_BITS-1:0];
   assign in_car      = in_car_ext[FLOOR_BITS-1:0];
   assign rd_floor    = rd_data_ff[FLOOR_BITS-1:0];
   assign rd_up       = rd_data_ff[FLOOR_BITS];
   assign rd_floor_ext = EXT_W'(rd_floor);
   assign idx_dec     = idx_ff - CNT_W'(1);
   assign idx_inc     = idx_ff + CNT_W'(1);

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_load  = out_free && (state_ff == S_REP_OUT || state_ff == S_DONE);
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   // Call goes ahead of the head when it lies between car and head, same way
   assign head_hit = (car_ff < tgt_ff && tgt_ff < rd_floor && up_ff) ||
                     (car_ff > tgt_ff && tgt_ff > rd_floor && !up_ff);

   always_comb begin
      if (prev_up_ff) begin
         if (!rd_up) mid_hit = (prev_floor_ff > tgt_ff && tgt_ff > rd_floor);
         else        mid_hit = (up_ff && prev_floor_ff < tgt_ff && tgt_ff < rd_floor);
      end else begin
         if (rd_up)  mid_hit = (prev_floor_ff < tgt_ff && tgt_ff < rd_floor);
         else        mid_hit = (!up_ff && prev_floor_ff > tgt_ff && tgt_ff > rd_floor);
      end
   end

   assign acc_hop    = acc_ff + ACC_W'(gap(prev_floor_ff, rd_floor));
   assign acc_to_tgt = acc_ff + ACC_W'(gap(prev_floor_ff, tgt_ff));
   assign rep_dist   = (idx_ff == '0) ? ACC_W'(gap(car_ff, rd_floor)) : acc_hop;

   assign fill_ext  = OCC_W'(fill_ff);
   assign occ_sat   = (fill_ext > OCC_W'(OCC_MAX)) ? OCC_MAX : fill_ext[OCC_BITS-1:0];
   assign idx_ext   = STP_W'(idx_ff);
   assign stops_sat = (idx_ext > STP_W'(STOP_MAX)) ? STOP_MAX : idx_ext[STOP_BITS-1:0];

   always_comb begin
      mem_re    = 1'b0;
      mem_raddr = idx_ff[IDX_W-1:0];
      mem_we    = 1'b0;
      mem_waddr = idx_ff[IDX_W-1:0];
      mem_wdata = rd_data_ff;
      case (state_ff)
         S_LOC_RD, S_REP_RD: begin
            mem_re = 1'b1;
         end
         S_SH_RD: begin
            if (idx_ff == pos_ff) begin
               mem_we    = 1'b1;
               mem_wdata = {set_ff, up_ff, tgt_ff};
            end else begin
               mem_re    = 1'b1;
               mem_raddr = idx_dec[IDX_W-1:0];
            end
         end
         S_SH_WR, S_POP_WR: begin
            mem_we = 1'b1;
         end
         S_POP_RD: begin
            if (idx_inc != fill_ff) begin
               mem_re    = 1'b1;
               mem_raddr = idx_inc[IDX_W-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) queue_ff[mem_waddr] <= mem_wdata;
      if (mem_re) rd_data_ff <= queue_ff[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  op_ff     <= op_type'(req_operation);
                  tgt_ff    <= in_tgt;
                  up_ff     <= req_call_up;
                  set_ff    <= req_call_set;
                  car_ff    <= in_car;
                  status_ff <= STATUS_OK;
                  idx_ff    <= '0;
                  pos_ff    <= '0;
                  acc_ff    <= ACC_W'(gap(in_car, in_tgt));
                  case (op_type'(req_operation))
                     OP_ADD: begin
                        if (fill_ff == CNT_W'(QUEUE_DEPTH)) begin
                           status_ff <= STATUS_FULL;
                           state_ff  <= S_DONE;
                        end else if (fill_ff == '0) begin
                           state_ff <= S_SH_RD;
                        end else begin
                           state_ff <= S_LOC_RD;
                        end
                     end
                     OP_POP: begin
                        if (fill_ff == '0) begin
                           status_ff <= STATUS_EMPTY;
                           state_ff  <= S_DONE;
                        end else begin
                           state_ff <= S_POP_RD;
                        end
                     end
                     OP_ESTIMATE: begin
                        state_ff <= (fill_ff == '0) ? S_DONE : S_LOC_RD;
                     end
                     OP_REPORT: begin
                        if (fill_ff == '0) begin
                           status_ff <= STATUS_EMPTY;
                           state_ff  <= S_DONE;
                        end else begin
                           state_ff <= S_REP_RD;
                        end
                     end
                     default: begin
                        state_ff <= S_DONE;
                     end
                  endcase
               end
            end
            S_LOC_RD: begin
               state_ff <= S_LOC_CHK;
            end
            S_LOC_CHK: begin
               prev_floor_ff <= rd_floor;
               prev_up_ff    <= rd_up;
               if (idx_ff == '0) begin
                  if (head_hit) begin
                     // acc already holds |car - call|
                     pos_ff   <= '0;
                     idx_ff   <= fill_ff;
                     state_ff <= (op_ff == OP_ADD) ? S_SH_RD : S_DONE;
                  end else begin
                     acc_ff   <= ACC_W'(gap(rd_floor, car_ff));
                     idx_ff   <= idx_inc;
                     state_ff <= (idx_inc == fill_ff) ? S_LOC_END : S_LOC_RD;
                  end
               end else if (mid_hit) begin
                  acc_ff   <= acc_to_tgt;
                  pos_ff   <= idx_ff;
                  idx_ff   <= fill_ff;
                  state_ff <= (op_ff == OP_ADD) ? S_SH_RD : S_DONE;
               end else begin
                  acc_ff   <= acc_hop;
                  idx_ff   <= idx_inc;
                  state_ff <= (idx_inc == fill_ff) ? S_LOC_END : S_LOC_RD;
               end
            end
            S_LOC_END: begin
               // no gap fits: append at the tail
               acc_ff   <= acc_to_tgt;
               pos_ff   <= fill_ff;
               idx_ff   <= fill_ff;
               state_ff <= (op_ff == OP_ADD) ? S_SH_RD : S_DONE;
            end
            S_SH_RD: begin
               if (idx_ff == pos_ff) begin
                  fill_ff  <= fill_ff + CNT_W'(1);
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_SH_WR;
               end
            end
            S_SH_WR: begin
               idx_ff   <= idx_dec;
               state_ff <= S_SH_RD;
            end
            S_POP_RD: begin
               if (idx_inc == fill_ff) begin
                  fill_ff  <= fill_ff - CNT_W'(1);
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_POP_WR;
               end
            end
            S_POP_WR: begin
               idx_ff   <= idx_inc;
               state_ff <= S_POP_RD;
            end
            S_REP_RD: begin
               state_ff <= S_REP_OUT;
            end
            S_REP_OUT: begin
               if (out_free) begin
                  acc_ff               <= rep_dist;
                  prev_floor_ff        <= rd_floor;
                  rsp_status_ff        <= STATUS_OK;
                  rsp_distance_ff      <= '0;
                  rsp_entry_floor_ff   <= rd_floor_ext[CALL_BITS-1:0];
                  rsp_entry_up_ff      <= rd_up;
                  rsp_floors_before_ff <= sat_dist(rep_dist);
                  rsp_stops_before_ff  <= stops_sat;
                  rsp_last_ff          <= (idx_inc == fill_ff);
                  rsp_occupancy_ff     <= occ_sat;
                  idx_ff               <= idx_inc;
                  state_ff             <= (idx_inc == fill_ff) ? S_IDLE : S_REP_RD;
               end
            end
            S_DONE: begin
               if (out_free) begin
                  rsp_status_ff        <= status_ff;
                  rsp_distance_ff      <= (op_ff == OP_ESTIMATE) ? sat_dist(acc_ff) : '0;
                  rsp_entry_floor_ff   <= '0;
                  rsp_entry_up_ff      <= 1'b0;
                  rsp_floors_before_ff <= '0;
                  rsp_stops_before_ff  <= '0;
                  rsp_last_ff          <= 1'b1;
                  rsp_occupancy_ff     <= occ_sat;
                  state_ff             <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_distance      = rsp_distance_ff;
   assign rsp_entry_floor   = rsp_entry_floor_ff;
   assign rsp_entry_up      = rsp_entry_up_ff;
   assign rsp_floors_before = rsp_floors_before_ff;
   assign rsp_stops_before  = rsp_stops_before_ff;
   assign rsp_last          = rsp_last_ff;
   assign rsp_occupancy     = rsp_occupancy_ff;

endmodule

// ===== test/tb_elevator_call_queue_scheduler.sv =====
module tb_elevator_call_queue_scheduler;
   timeunit 1ns;
   timeprecision 1ps;

   import ecqs_pkg::*;

   localparam int QUEUE_DEPTH  = QUEUE_DEPTH_DEF;
   localparam int FLOOR_BITS   = FLOOR_BITS_DEF;
   localparam int unsigned FLOOR_MASK = (1 << FLOOR_BITS) - 1;
   localparam int RANDOM_ITEMS = 250;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 4 * QUEUE_DEPTH + 40;
   localparam int HOLD_CYCLES  = 400;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [DIST_BITS-1:0]   distance;
      logic [CALL_BITS-1:0]   entry_floor;
      logic                   entry_up;
      logic [DIST_BITS-1:0]   floors_before;
      logic [STOP_BITS-1:0]   stops_before;
      logic                   last;
      logic [OCC_BITS-1:0]    occupancy;
   } sched_beat_type;

   typedef struct {
      op_type               op;
      logic [CALL_BITS-1:0] call_floor;
      logic                 call_up;
      logic                 call_set;
      logic [CALL_BITS-1:0] car_floor;
   } call_req_type;

   typedef struct {
      call_req_type   req;
      bit             fixed;
      sched_beat_type beat;
   } plan_row_type;

   logic                   clock;
   logic                   reset          = 1'b1;
   logic                   req_valid      = 1'b0;
   logic                   req_stall;
   logic [OP_BITS-1:0]     req_operation  = '0;
   logic [CALL_BITS-1:0]   req_call_floor = '0;
   logic                   req_call_up    = 1'b0;
   logic                   req_call_set   = 1'b0;
   logic [CALL_BITS-1:0]   req_car_floor  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall      = 1'b0;
   logic [STATUS_BITS-1:0] rsp_status;
   logic [DIST_BITS-1:0]   rsp_distance;
   logic [CALL_BITS-1:0]   rsp_entry_floor;
   logic                   rsp_entry_up;
   logic [DIST_BITS-1:0]   rsp_floors_before;
   logic [STOP_BITS-1:0]   rsp_stops_before;
   logic                   rsp_last;
   logic [OCC_BITS-1:0]    rsp_occupancy;

   elevator_call_queue_scheduler #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .FLOOR_BITS (FLOOR_BITS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_call_floor   (req_call_floor),
      .req_call_up      (req_call_up),
      .req_call_set     (req_call_set),
      .req_car_floor    (req_car_floor),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_distance     (rsp_distance),
      .rsp_entry_floor  (rsp_entry_floor),
      .rsp_entry_up     (rsp_entry_up),
      .rsp_floors_before(rsp_floors_before),
      .rsp_stops_before (rsp_stops_before),
      .rsp_last         (rsp_last),
      .rsp_occupancy    (rsp_occupancy)
   );

   // shadow copy of the call queue
   logic [CALL_BITS-1:0] call_floor_q [QUEUE_DEPTH];
   logic                 call_up_q    [QUEUE_DEPTH];
   logic                 call_set_q   [QUEUE_DEPTH];
   int unsigned          calls_held;

   sched_beat_type  pending_beats[$];
   sched_beat_type  expected_beats[$];
   plan_row_type    directed_rows[$];

   bit           steady;
   int unsigned  cycle_count;
   int unsigned  items_accepted;
   int unsigned  beats_seen;
   int unsigned  mismatches;
   int unsigned  full_drops;
   int unsigned  empty_hits;
   int unsigned  peak_calls;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned span(input int unsigned a, input int unsigned b);
      return (a > b) ? a - b : b - a;
   endfunction

   function automatic int unsigned clip(input int unsigned v, input int unsigned top);
      return (v > top) ? top : v;
   endfunction

   function automatic sched_beat_type make_beat(input logic [STATUS_BITS-1:0] status,
                                                input int unsigned travel,
                                                input int unsigned ef, input bit eu,
                                                input int unsigned fb, input int unsigned sb,
                                                input bit last);
      sched_beat_type b;
      b.status        = status;
      b.distance      = DIST_BITS'(clip(travel, DIST_MAX));
      b.entry_floor   = CALL_BITS'(ef);
      b.entry_up      = eu;
      b.floors_before = DIST_BITS'(clip(fb, DIST_MAX));
      b.stops_before  = STOP_BITS'(clip(sb, STOP_MAX));
      b.last          = last;
      b.occupancy     = OCC_BITS'(clip(calls_held, OCC_MAX));
      return b;
   endfunction

   // insertion slot for a call, plus travel from the car to it
   function automatic int unsigned find_slot(input int unsigned t, input bit up,
                                             input int unsigned car,
                                             output int unsigned travel);
      int unsigned i, h, acc, cf, nf;
      bit cu, nu, hit;
      if (calls_held == 0) begin
         travel = span(car, t);
         return 0;
      end
      h = call_floor_q[0];
      if ((car < t && t < h && up) || (car > t && t > h && !up)) begin
         travel = span(car, t);
         return 0;
      end
      acc = span(h, car);
      for (i = 0; i + 1 < calls_held; i++) begin
         cf = call_floor_q[i];
         nf = call_floor_q[i+1];
         cu = call_up_q[i];
         nu = call_up_q[i+1];
         if (cu) hit = !nu ? (cf > t && t > nf) : (up && cf < t && t < nf);
         else    hit = nu ? (cf < t && t < nf) : (!up && cf > t && t > nf);
         if (hit) begin
            travel = acc + span(cf, t);
            return i + 1;
         end
         acc += span(cf, nf);
      end
      travel = acc + span(call_floor_q[calls_held-1], t);
      return calls_held;
   endfunction

   task automatic predict_request(input call_req_type r);
      int unsigned t, car, travel, pos, i;
      t   = r.call_floor & FLOOR_MASK;
      car = r.car_floor & FLOOR_MASK;
      pending_beats.delete();
      case (r.op)
         OP_ADD: begin
            if (calls_held >= QUEUE_DEPTH) begin
               full_drops++;
               pending_beats.push_back(make_beat(STATUS_FULL, 0, 0, 0, 0, 0, 1));
            end else begin
               pos = find_slot(t, r.call_up, car, travel);
               for (i = calls_held; i > pos; i--) begin
                  call_floor_q[i] = call_floor_q[i-1];
                  call_up_q[i]    = call_up_q[i-1];
                  call_set_q[i]   = call_set_q[i-1];
               end
               call_floor_q[pos] = CALL_BITS'(t);
               call_up_q[pos]    = r.call_up;
               call_set_q[pos]   = r.call_set;
               calls_held++;
               if (calls_held > peak_calls) peak_calls = calls_held;
               pending_beats.push_back(make_beat(STATUS_OK, 0, 0, 0, 0, 0, 1));
            end
         end
         OP_POP: begin
            if (calls_held == 0) begin
               empty_hits++;
               pending_beats.push_back(make_beat(STATUS_EMPTY, 0, 0, 0, 0, 0, 1));
            end else begin
               for (i = 0; i + 1 < calls_held; i++) begin
                  call_floor_q[i] = call_floor_q[i+1];
                  call_up_q[i]    = call_up_q[i+1];
                  call_set_q[i]   = call_set_q[i+1];
               end
               calls_held--;
               pending_beats.push_back(make_beat(STATUS_OK, 0, 0, 0, 0, 0, 1));
            end
         end
         OP_ESTIMATE: begin
            pos = find_slot(t, r.call_up, car, travel);
            pending_beats.push_back(make_beat(STATUS_OK, travel, 0, 0, 0, 0, 1));
         end
         default: begin
            if (calls_held == 0) begin
               empty_hits++;
               pending_beats.push_back(make_beat(STATUS_EMPTY, 0, 0, 0, 0, 0, 1));
            end else begin
               travel = span(car, call_floor_q[0]);
               for (i = 0; i < calls_held; i++) begin
                  if (i > 0) travel += span(call_floor_q[i], call_floor_q[i-1]);
                  pending_beats.push_back(make_beat(STATUS_OK, 0, call_floor_q[i],
                                                    call_up_q[i], travel, i,
                                                    i + 1 == calls_held));
               end
            end
         end
      endcase
   endtask

   task automatic add_row(input op_type op, input int unsigned cf, input bit up,
                          input bit set, input int unsigned car, input bit fixed,
                          input logic [STATUS_BITS-1:0] status,
                          input int unsigned travel, input int unsigned occ);
      plan_row_type row;
      row.req.op         = op;
      row.req.call_floor = CALL_BITS'(cf);
      row.req.call_up    = up;
      row.req.call_set   = set;
      row.req.car_floor  = CALL_BITS'(car);
      row.fixed          = fixed;
      row.beat           = '{status: status, distance: DIST_BITS'(travel), last: 1'b1,
                             occupancy: OCC_BITS'(occ), default: '0};
      directed_rows.push_back(row);
   endtask

   // one request beat; expected results queued at the accepting edge
   task automatic send_request(input call_req_type r, input bit fixed,
                               input sched_beat_type lit);
      while (!steady && $urandom_range(99) < 14) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_operation  <= r.op;
      req_call_floor <= r.call_floor;
      req_call_up    <= r.call_up;
      req_call_set   <= r.call_set;
      req_car_floor  <= r.car_floor;
      req_valid      <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_accepted++;
      predict_request(r);
      if (fixed) expected_beats.push_back(lit);
      else foreach (pending_beats[k]) expected_beats.push_back(pending_beats[k]);
   endtask

   function automatic logic [CALL_BITS-1:0] pick_floor(input logic [CALL_BITS-1:0] car);
      int unsigned roll;
      int near;
      roll = $urandom_range(99);
      if (roll < 10) return '0;
      if (roll < 20) return '1;
      if (roll < 35) begin
         near = int'(car) + int'($urandom_range(6)) - 3;
         if (near < 0) near = 0;
         if (near > 255) near = 255;
         return CALL_BITS'(near);
      end
      return CALL_BITS'($urandom_range(255));
   endfunction

   task automatic check_beat();
      sched_beat_type got, want;
      got = '{rsp_status, rsp_distance, rsp_entry_floor, rsp_entry_up,
              rsp_floors_before, rsp_stops_before, rsp_last, rsp_occupancy};
      beats_seen++;
      if (expected_beats.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("beat %0d: no result was due, got st=%0d occ=%0d",
                     beats_seen, got.status, got.occupancy);
         return;
      end
      want = expected_beats.pop_front();
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("beat %0d mismatch: want st=%0d dist=%0d ef=%0d up=%0d fb=%0d sb=%0d last=%0d occ=%0d",
                     beats_seen, want.status, want.distance, want.entry_floor,
                     want.entry_up, want.floors_before, want.stops_before,
                     want.last, want.occupancy);
            $display("                  got  st=%0d dist=%0d ef=%0d up=%0d fb=%0d sb=%0d last=%0d occ=%0d",
                     got.status, got.distance, got.entry_floor, got.entry_up,
                     got.floors_before, got.stops_before, got.last, got.occupancy);
         end
      end
   endtask

   initial begin : response_side
      int unsigned hold_left;
      bit held;
      hold_left = 0;
      held      = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) check_beat();
         // one long hold-off so the block backs up into the request side
         if (!held && beats_seen >= 80) begin
            held      = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (beats_seen >= 300 && beats_seen < 500) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < 14);
         end
      end
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_beats.size());
      $display("[elevator_call_queue_scheduler] ERROR");
      $finish;
   end

   initial begin : request_side
      call_req_type r;
      op_type op;
      logic [CALL_BITS-1:0] car;
      int unsigned n, roll;
      bit filling;

      calls_held = 0;
      steady     = 1'b0;

      // empty queue, extremes of floor distance, then build a queue to full and query it
      add_row(OP_POP,      0,   0, 0, 0,   1, STATUS_EMPTY, 0,   0);
      add_row(OP_REPORT,   255, 1, 1, 255, 1, STATUS_EMPTY, 0,   0);
      add_row(OP_ESTIMATE, 255, 1, 1, 0,   1, STATUS_OK,    255, 0);
      add_row(OP_ESTIMATE, 0,   0, 0, 255, 1, STATUS_OK,    255, 0);
      add_row(OP_ADD,      100, 1, 1, 50,  0, STATUS_OK,    0,   0);
      add_row(OP_ADD,      75,  1, 1, 50,  0, STATUS_OK,    0,   0); // ahead of head
      add_row(OP_ADD,      200, 0, 1, 50,  0, STATUS_OK,    0,   0);
      add_row(OP_ADD,      150, 1, 0, 50,  0, STATUS_OK,    0,   0);
      add_row(OP_ADD,      0,   0, 0, 255, 0, STATUS_OK,    0,   0);
      add_row(OP_ADD,      255, 1, 1, 0,   0, STATUS_OK,    0,   0);
      add_row(OP_ESTIMATE, 120, 1, 0, 60,  0, STATUS_OK,    0,   0);
      add_row(OP_REPORT,   0,   0, 0, 60,  0, STATUS_OK,    0,   0);
      add_row(OP_ADD,      180, 0, 1, 190, 0, STATUS_OK,    0,   0);
      add_row(OP_ADD,      90,  1, 1, 80,  0, STATUS_OK,    0,   0);
      add_row(OP_ADD,      30,  0, 0, 40,  0, STATUS_OK,    0,   0);
      add_row(OP_ADD,      60,  1, 1, 20,  0, STATUS_OK,    0,   0);
      add_row(OP_ADD,      220, 0, 1, 240, 0, STATUS_OK,    0,   0);
      add_row(OP_ADD,      128, 1, 0, 127, 0, STATUS_OK,    0,   0);
      add_row(OP_ADD,      5,   0, 1, 10,  0, STATUS_OK,    0,   0);
      add_row(OP_ADD,      250, 1, 1, 245, 0, STATUS_OK,    0,   0);
      add_row(OP_ADD,      170, 0, 0, 160, 0, STATUS_OK,    0,   0);
      add_row(OP_ADD,      110, 1, 1, 105, 0, STATUS_OK,    0,   0);
      add_row(OP_ADD,      42,  1, 1, 7,   1, STATUS_FULL,  0,   QUEUE_DEPTH);
      add_row(OP_REPORT,   0,   1, 0, 255, 0, STATUS_OK,    0,   0);
      add_row(OP_POP,      0,   0, 0, 0,   0, STATUS_OK,    0,   0);
      add_row(OP_ESTIMATE, 0,   0, 0, 255, 0, STATUS_OK,    0,   0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[k])
         send_request(directed_rows[k].req, directed_rows[k].fixed, directed_rows[k].beat);

      // drift between filling and draining so occupancy sweeps empty..full
      filling = 1'b0;
      car     = CALL_BITS'($urandom_range(255));
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0) filling = !filling;
         roll = $urandom_range(99);
         if (filling) op = (roll < 55) ? OP_ADD : (roll < 70) ? OP_POP :
                           (roll < 85) ? OP_ESTIMATE : OP_REPORT;
         else         op = (roll < 15) ? OP_ADD : (roll < 70) ? OP_POP :
                           (roll < 85) ? OP_ESTIMATE : OP_REPORT;
         if ($urandom_range(99) < 30) car = CALL_BITS'($urandom_range(255));
         r.op         = op;
         r.call_floor = pick_floor(car);
         r.call_up    = $urandom_range(1);
         r.call_set   = $urandom_range(1);
         r.car_floor  = car;
         steady       = (n >= 120 && n < 180);
         send_request(r, 1'b0, '0);
      end
      @(posedge clock);
      req_valid <= 1'b0;

      while (expected_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d requests (%0d directed), %0d result beats, %0d mismatches",
               items_accepted, directed_rows.size(), beats_seen, mismatches);
      $display("queue peaked at %0d calls; %0d dropped on full, %0d empty pops/reports",
               peak_calls, full_drops, empty_hits);
      if (mismatches == 0 && expected_beats.size() == 0)
         $display("[elevator_call_queue_scheduler] OK");
      else
         $display("[elevator_call_queue_scheduler] ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/ecqs_pkg.sv
hw/rtl/elevator_call_queue_scheduler.sv
test/tb_elevator_call_queue_scheduler.sv
